### rtl/fpsqrt_pkg.sv
// Shared types and constants for the fixed-point square root pipeline.
// No dependencies; used by every module under rtl.
package fpsqrt_pkg;

  localparam int unsigned RAD_W         = 32;
  localparam int unsigned ROOT_W        = 31;
  localparam int unsigned REM_W         = 31;
  localparam int unsigned FRAC_W        = 5;
  localparam int unsigned NUM_STEPS     = 16;
  localparam int unsigned STEPS_PER_STG = 2;
  localparam int unsigned NUM_STG       = NUM_STEPS / STEPS_PER_STG;
  localparam int unsigned WIDE_W        = 64;

  localparam logic [REM_W-1:0]  TEST_SEED  = 31'h4000_0001;
  localparam logic [FRAC_W-1:0] FRAC_RESET = 5'd15;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [REM_W-1:0]  root;
    logic [FRAC_W-1:0] even;
    logic              neg;
  } sq_data_t;

  // test bit for one recurrence step; step 0 keeps the low one
  function automatic logic [REM_W-1:0] test_bit(input int unsigned step);
    test_bit = TEST_SEED >> (2 * step);
  endfunction

endpackage

### rtl/fixed_point_square_root.sv
// Top level of the pipelined fixed-point square root.
// Depends on fpsqrt_pkg, fpsqrt_stage and fpsqrt_align.
//
// Input channel: in_valid / in_stall, one signed radicand per beat in the Q
// format set by the input_frac_bits register. Result channel: out_valid /
// out_stall, one Q15 (OUT_FRAC_BITS) root per beat, in input order. A
// negative radicand gives a zero root.
// Configuration: cfg_valid / cfg_ready with cfg_data carrying input_frac_bits;
// cfg_ready is always high. The count is sampled as each beat enters, so
// write it only while the pipeline is empty.
// The datapath holds one input register, eight stages of two recurrence
// steps each and one rounding/alignment register. Throughput is one beat per
// cycle with no bubbles while the receiver takes results.
// When out_stall is high the pipeline fills up behind the held result; each
// stage still accepts while it is empty, and in_stall rises once the input
// register is full and cannot move on. Nothing is dropped or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and sets
// input_frac_bits to 15.
module fixed_point_square_root #(
  parameter int unsigned OUT_FRAC_BITS = 15
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [fpsqrt_pkg::RAD_W-1:0]  in_radicand,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [fpsqrt_pkg::ROOT_W-1:0] out_root_q15,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [fpsqrt_pkg::FRAC_W-1:0] cfg_data
);

  logic [fpsqrt_pkg::FRAC_W-1:0] frac_r;
  logic                          prep_valid_r;
  fpsqrt_pkg::sq_data_t          prep_r;
  fpsqrt_pkg::sq_data_t          prep_nxt;
  logic                          prep_ready;

  logic                 stg_valid [fpsqrt_pkg::NUM_STG+1];
  logic                 stg_ready [fpsqrt_pkg::NUM_STG+1];
  fpsqrt_pkg::sq_data_t stg_data  [fpsqrt_pkg::NUM_STG+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r <= fpsqrt_pkg::FRAC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frac_r <= cfg_data;
    end
  end

  // odd count: drop to even and halve the radicand
  always_comb begin
    prep_nxt.neg  = in_radicand[fpsqrt_pkg::RAD_W-1];
    prep_nxt.even = {frac_r[fpsqrt_pkg::FRAC_W-1:1], 1'b0};
    prep_nxt.root = '0;
    if (frac_r[0]) begin
      prep_nxt.rem = in_radicand[fpsqrt_pkg::RAD_W-1:1];
    end else begin
      prep_nxt.rem = in_radicand[fpsqrt_pkg::REM_W-1:0];
    end
  end

  assign prep_ready = !prep_valid_r || stg_ready[0];
  assign in_stall   = !prep_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_valid_r <= 1'b0;
    end else if (prep_ready) begin
      prep_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prep_ready && in_valid) begin
      prep_r <= prep_nxt;
    end
  end

  assign stg_valid[0] = prep_valid_r;
  assign stg_data[0]  = prep_r;

  for (genvar g = 0; g < fpsqrt_pkg::NUM_STG; g++) begin : g_stage
    fpsqrt_stage #(
      .FIRST_STEP(g * fpsqrt_pkg::STEPS_PER_STG)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (stg_valid[g]),
      .in_ready (stg_ready[g]),
      .in_data  (stg_data[g]),
      .out_valid(stg_valid[g+1]),
      .out_ready(stg_ready[g+1]),
      .out_data (stg_data[g+1])
    );
  end

  fpsqrt_align #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_align (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (stg_valid[fpsqrt_pkg::NUM_STG]),
    .in_ready (stg_ready[fpsqrt_pkg::NUM_STG]),
    .in_data  (stg_data[fpsqrt_pkg::NUM_STG]),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_root (out_root_q15)
  );

endmodule

### rtl/fpsqrt_stage.sv
// One pipeline stage of the restoring square root: a few recurrence steps
// followed by a data register. Depends on fpsqrt_pkg.
module fpsqrt_stage #(
  parameter int unsigned FIRST_STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fpsqrt_pkg::sq_data_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fpsqrt_pkg::sq_data_t out_data
);

  logic                 valid_r;
  fpsqrt_pkg::sq_data_t data_r;
  fpsqrt_pkg::sq_data_t data_nxt;

  always_comb begin
    logic [fpsqrt_pkg::REM_W-1:0] bit_v;
    logic [fpsqrt_pkg::REM_W:0]   sum_v;
    data_nxt = in_data;
    for (int unsigned k = 0; k < fpsqrt_pkg::STEPS_PER_STG; k++) begin
      bit_v = fpsqrt_pkg::test_bit(FIRST_STEP + k);
      sum_v = {1'b0, bit_v} + {1'b0, data_nxt.root};
      if (sum_v <= {1'b0, data_nxt.rem}) begin
        data_nxt.rem  = data_nxt.rem - sum_v[fpsqrt_pkg::REM_W-1:0];
        data_nxt.root = (data_nxt.root >> 1) | bit_v;
      end else begin
        data_nxt.root = data_nxt.root >> 1;
      end
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### rtl/fpsqrt_align.sv
// Output stage: rounds the root, aligns it to the output Q format and holds
// the result beat for the receiver. Depends on fpsqrt_pkg.
module fpsqrt_align #(
  parameter int unsigned OUT_FRAC_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fpsqrt_pkg::sq_data_t          in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fpsqrt_pkg::ROOT_W-1:0] out_root
);

  localparam logic [5:0] OFB = 6'(OUT_FRAC_BITS);

  logic                          valid_r;
  logic [fpsqrt_pkg::ROOT_W-1:0] root_r;
  logic [fpsqrt_pkg::ROOT_W-1:0] root_nxt;
  logic [fpsqrt_pkg::REM_W:0]    rounded;
  logic [fpsqrt_pkg::WIDE_W-1:0] scaled;
  logic [fpsqrt_pkg::WIDE_W-1:0] aligned;
  logic [5:0]                    even6;

  always_comb begin
    rounded = {1'b0, in_data.root} +
              {{fpsqrt_pkg::REM_W{1'b0}}, (in_data.root < in_data.rem)};
    scaled  = {{(fpsqrt_pkg::WIDE_W - fpsqrt_pkg::REM_W - 1){1'b0}}, rounded}
              << in_data.even[fpsqrt_pkg::FRAC_W-1:1];
    even6   = {1'b0, in_data.even};
    if (even6 < OFB) begin
      aligned = scaled << (OFB - even6);
    end else begin
      aligned = scaled >> (even6 - OFB);
    end
    root_nxt = in_data.neg ? '0 : aligned[fpsqrt_pkg::ROOT_W-1:0];
  end

  assign in_ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      root_r <= root_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_root  = root_r;

endmodule

### tb/sv/fpsqrt_checker.sv
`timescale 1ns / 100ps
// Scoreboard for fixed_point_square_root: tracks the fraction-bit count, predicts each
// Q15 root from the radicand beat and checks result beats in order. Depends on fpsqrt_pkg.
module fpsqrt_checker #(
  parameter int unsigned OUT_FRAC_BITS = 15
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic signed [fpsqrt_pkg::RAD_W-1:0]  in_radicand,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic        [fpsqrt_pkg::ROOT_W-1:0] out_root_q15,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic        [fpsqrt_pkg::FRAC_W-1:0] cfg_data,
  output int                                   fail_count,
  output int                                   pending,
  output int                                   roots_checked
);

  logic [fpsqrt_pkg::FRAC_W-1:0] frac_bits;
  logic [fpsqrt_pkg::ROOT_W-1:0] expected_roots[$];
  logic [fpsqrt_pkg::ROOT_W-1:0] want;
  int                            errors = 0;
  int                            checked = 0;

  function automatic logic [fpsqrt_pkg::ROOT_W-1:0] q15_root(
    input logic signed [fpsqrt_pkg::RAD_W-1:0]  rad,
    input logic        [fpsqrt_pkg::FRAC_W-1:0] frac
  );
    longint      val;
    longint      root;
    longint      tbit;
    logic [4:0]  even;
    logic [63:0] wide;
    int          step;
    val  = rad;
    root = 0;
    even = frac;
    // odd count: drop to even, halve the radicand
    if (even[0]) begin
      even = even - 5'd1;
      val  = val >>> 1;
    end
    if (val < 0) return '0;
    for (step = 0; step < fpsqrt_pkg::NUM_STEPS; step++) begin
      tbit = longint'(fpsqrt_pkg::TEST_SEED) >>> (2 * step);
      if (tbit + root <= val) begin
        val  = val - (tbit + root);
        root = (root >>> 1) | tbit;
      end else begin
        root = root >>> 1;
      end
    end
    if (root < val) root = root + 1;
    wide = 64'(root) << (even / 2);
    if (int'(even) < int'(OUT_FRAC_BITS)) begin
      wide = wide << (int'(OUT_FRAC_BITS) - int'(even));
    end else begin
      wide = wide >> (int'(even) - int'(OUT_FRAC_BITS));
    end
    return wide[fpsqrt_pkg::ROOT_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      frac_bits <= fpsqrt_pkg::FRAC_RESET;
      expected_roots.delete();
    end else begin
      if (cfg_valid && cfg_ready) frac_bits <= cfg_data;
      if (out_valid && !out_stall) begin
        if (expected_roots.size() == 0) begin
          $error("root_q15: unexpected result beat, actual %0d", out_root_q15);
          errors++;
        end else begin
          want = expected_roots.pop_front();
          checked++;
          if (out_root_q15 !== want) begin
            $error("root_q15 mismatch: expected %0d, actual %0d", want, out_root_q15);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) expected_roots.push_back(q15_root(in_radicand, frac_bits));
    end
    pending       <= expected_roots.size();
    fail_count    <= errors;
    roots_checked <= checked;
  end

endmodule

### tb/sv/tb_fixed_point_square_root.sv
`timescale 1ns / 100ps
// Top of the fixed_point_square_root testbench: clock, reset, radicand and config stimulus,
// random output stalls and the verdict. Depends on fpsqrt_pkg, fpsqrt_checker and the RTL.
module tb_fixed_point_square_root;

  localparam int unsigned OUT_Q           = 15;
  localparam int          CYCLE_LIMIT     = 200000;
  localparam int          HOLD_LEN        = 64;
  localparam int          HOLD_EVERY      = 600;
  localparam int          NUM_CORNERS     = 20;
  localparam int          NUM_SETTINGS    = 9;
  localparam int          RANDOM_AT_RESET = 150;
  localparam int          RANDOM_PER_SET  = 186;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic signed [fpsqrt_pkg::RAD_W-1:0]  in_radicand = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic        [fpsqrt_pkg::ROOT_W-1:0] out_root_q15;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic        [fpsqrt_pkg::FRAC_W-1:0] cfg_data = '0;

  logic calm = 1'b0;
  int   beats_sent = 0;
  int   hold_left = 0;
  int   next_hold = 400;
  int   holds = 0;
  int   cycles = 0;
  int   fail_count;
  int   pending;
  int   roots_checked;

  always #5 clk = ~clk;

  fixed_point_square_root #(.OUT_FRAC_BITS(OUT_Q)) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_radicand  (in_radicand),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_root_q15 (out_root_q15),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  fpsqrt_checker #(.OUT_FRAC_BITS(OUT_Q)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_radicand   (in_radicand),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_root_q15  (out_root_q15),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .roots_checked (roots_checked)
  );

  // receiver: random stalls, plus a long hold-off every so many beats
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (beats_sent >= next_hold) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_LEN;
      next_hold <= next_hold + HOLD_EVERY;
      holds     <= holds + 1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 14);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic signed [fpsqrt_pkg::RAD_W-1:0] corner(input int idx);
    case (idx)
      0:       return 32'sh0000_0000;
      1:       return 32'sh0000_0001;
      2:       return 32'sh0000_0002;
      3:       return 32'sh0000_0003;
      4:       return 32'sh0000_0004;
      5:       return 32'sh7FFF_FFFF;
      6:       return 32'sh8000_0000;
      7:       return 32'shFFFF_FFFF;
      8:       return 32'shFFFF_FFFE;
      9:       return 32'sh4000_0000;
      10:      return 32'sh4000_0001;
      11:      return 32'sh3FFF_FFFF;
      12:      return 32'sh0000_8000;
      13:      return 32'sh0001_0000;
      14:      return 32'sh0000_FFFF;
      15:      return 32'sh7FFE_A810;
      16:      return 32'sh7FFE_A811;
      17:      return 32'sh5555_5555;
      18:      return 32'shAAAA_AAAA;
      default: return 32'sh0000_0010;
    endcase
  endfunction

  function automatic logic [fpsqrt_pkg::FRAC_W-1:0] frac_setting(input int idx);
    case (idx)
      0:       return 5'd0;
      1:       return 5'd31;
      2:       return 5'd30;
      3:       return 5'd1;
      4:       return 5'd14;
      5:       return 5'd16;
      6:       return 5'd29;
      7:       return 5'd7;
      default: return 5'd15;
    endcase
  endfunction

  function automatic logic signed [fpsqrt_pkg::RAD_W-1:0] pick_radicand();
    logic signed [fpsqrt_pkg::RAD_W-1:0] r;
    int                                  k;
    case ($urandom_range(9))
      0: begin
        r = $urandom;
        r[fpsqrt_pkg::RAD_W-1] = 1'b1;
      end
      1: r = corner($urandom_range(11));
      2: begin
        k = $urandom_range(46340);
        r = k * k + int'($urandom_range(2)) - 1;
      end
      default: r = $urandom >> $urandom_range(1, 31);
    endcase
    return r;
  endfunction

  task automatic send_beat(input logic signed [fpsqrt_pkg::RAD_W-1:0] rad);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_radicand <= rad;
    do @(posedge clk); while (in_stall);
    beats_sent <= beats_sent + 1;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_frac(input logic [fpsqrt_pkg::FRAC_W-1:0] frac);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= frac;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int p;
    int i;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (i = 0; i < NUM_CORNERS; i++) send_beat(corner(i));
    for (i = 0; i < RANDOM_AT_RESET; i++) send_beat(pick_radicand());
    for (p = 0; p < NUM_SETTINGS; p++) begin
      write_frac(frac_setting(p));
      calm <= (p == 3);
      for (i = 0; i < RANDOM_PER_SET; i++) begin
        // sender waits for the pipe to empty mid-phase
        if (p == 5 && i == RANDOM_PER_SET / 2) drain();
        send_beat(pick_radicand());
      end
    end
    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d radicands over %0d fraction-bit settings incl. reset value; %0d roots",
             beats_sent, NUM_SETTINGS + 1, roots_checked);
    $display("compared, with %0d long output hold-offs and one stall-free phase.", holds);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
